// ----- hdl/tsd_pkg.sv -----
// Package: shared types and constants of the tar stream deframer.
package tsd_pkg;

  localparam int unsigned BLOCK_LAST = 511;  // last byte index of a 512-byte block
  localparam int unsigned SIZE_FIRST = 124;  // first byte of the octal size field
  localparam int unsigned SIZE_LAST  = 135;  // last byte of the octal size field
  localparam int unsigned NAME_LEN   = 100;  // bytes of the name field
  localparam int unsigned TAIL_LEN   = 11;   // length of "config.json"

  localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;

  // "config.json", oldest character first
  localparam logic [7:0] CFG_NAME [TAIL_LEN] = '{
    8'h63, 8'h6F, 8'h6E, 8'h66, 8'h69, 8'h67, 8'h2E, 8'h6A, 8'h73, 8'h6F, 8'h6E
  };

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_CONFIG  = 3'd1,
    KIND_FILE    = 3'd2,
    KIND_PADDING = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_CONTENT = 4'b0010,
    PH_PADDING = 4'b0100,
    PH_ENDED   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    SZ_SKIP   = 3'b001,
    SZ_DIGITS = 3'b010,
    SZ_DONE   = 3'b100
  } size_phase_t;

  // Byte class flags worked out by the front part
  typedef struct packed {
    logic is_zero;
    logic is_ws;
    logic is_plus;
    logic is_minus;
    logic is_octal;
  } byte_class_t;

  // One queued word: input fields plus its class
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_archive;
    logic        chunk_last;
    byte_class_t cls;
  } queue_word_t;

endpackage

// ----- hdl/tsd_if.sv -----
// Interfaces: input byte channel and labeled result channel.
interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_archive;
  logic       chunk_last;

  modport source (output valid, data_byte, start_of_archive, chunk_last, input ready);
  modport sink   (input valid, data_byte, start_of_archive, chunk_last, output ready);
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  data_out;
  logic        header_complete;
  logic [30:0] entry_size;
  logic        entry_is_config;
  logic        archive_end;
  logic        chunk_last_out;

  modport source (output valid, byte_kind, data_out, header_complete, entry_size,
                  entry_is_config, archive_end, chunk_last_out, input ready);
  modport sink   (input valid, byte_kind, data_out, header_complete, entry_size,
                  entry_is_config, archive_end, chunk_last_out, output ready);
endinterface

// ----- hdl/tsd_front.sv -----
// Front part: accept input words and classify each byte for the parser.
module tsd_front import tsd_pkg::*; (
  tsd_in_if.sink      archive,
  input  logic        full,
  output logic        push,
  output queue_word_t word
);

  logic [7:0] b;

  assign b             = archive.data_byte;
  assign archive.ready = !full;
  assign push          = archive.valid && !full;

  always_comb begin
    word.data_byte        = b;
    word.start_of_archive = archive.start_of_archive;
    word.chunk_last       = archive.chunk_last;
    word.cls.is_zero      = (b == 8'h00);
    // space, tab, LF, VT, FF, CR
    word.cls.is_ws        = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    word.cls.is_plus      = (b == 8'h2B);
    word.cls.is_minus     = (b == 8'h2D);
    word.cls.is_octal     = (b >= 8'h30 && b <= 8'h37);
  end

endmodule

// ----- hdl/tsd_queue.sv -----
// Short queue of classified words between the front and back parts.
module tsd_queue import tsd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  queue_word_t push_word,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output queue_word_t head_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  queue_word_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- hdl/tsd_back.sv -----
// Back part: tar header parser, entry state machine and output register.
module tsd_back import tsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  queue_word_t head_word,
  output logic        pop,
  tsd_out_if.source   labeled
);

  // parser state
  phase_t      phase;
  logic [8:0]  header_count;
  logic        any_nonzero;
  logic        name_ended;
  logic [7:0]  name_tail [TAIL_LEN];
  logic [3:0]  name_tail_fill;
  logic [30:0] size_accum;
  size_phase_t size_phase;
  logic [30:0] remaining_bytes;
  logic [30:0] current_size;
  logic        config_flag;

  // next values
  phase_t      phase_next;
  logic [8:0]  header_count_next;
  logic        any_nonzero_next;
  logic        name_ended_next;
  logic [7:0]  name_tail_next [TAIL_LEN];
  logic [3:0]  name_tail_fill_next;
  logic [30:0] size_accum_next;
  size_phase_t size_phase_next;
  logic [30:0] remaining_bytes_next;
  logic [30:0] current_size_next;
  logic        config_flag_next;

  kind_t       kind;
  logic        hc;
  logic        aend;
  logic        do_clear;
  logic        sof;
  logic        tail_match;
  logic [33:0] shifted;
  logic [30:0] dec;
  logic [8:0]  pad;
  logic        digit_ok;

  assign pop = head_valid && (!labeled.valid || labeled.ready);
  assign sof = head_word.start_of_archive;

  always_comb begin
    // restart: drop any partial header, content or padding
    phase_next           = sof ? PH_HEADER : phase;
    header_count_next    = sof ? '0 : header_count;
    any_nonzero_next     = sof ? 1'b0 : any_nonzero;
    name_ended_next      = sof ? 1'b0 : name_ended;
    name_tail_fill_next  = sof ? '0 : name_tail_fill;
    size_accum_next      = sof ? '0 : size_accum;
    size_phase_next      = sof ? SZ_SKIP : size_phase;
    remaining_bytes_next = sof ? '0 : remaining_bytes;
    for (int k = 0; k < TAIL_LEN; k++) begin
      name_tail_next[k] = sof ? 8'h00 : name_tail[k];
    end
    current_size_next = current_size;
    config_flag_next  = config_flag;
    kind       = KIND_IGNORED;
    hc         = 1'b0;
    aend       = 1'b0;
    do_clear   = 1'b0;
    tail_match = 1'b0;
    digit_ok   = 1'b0;
    shifted    = '0;
    pad        = '0;
    dec        = (remaining_bytes_next != '0) ? remaining_bytes_next - 1'b1 : '0;

    unique case (phase_next)
      PH_HEADER: begin
        kind = KIND_HEADER;
        if (!head_word.cls.is_zero) begin
          any_nonzero_next = 1'b1;
        end
        if (header_count_next < 9'(NAME_LEN) && !name_ended_next) begin
          if (head_word.cls.is_zero) begin
            name_ended_next = 1'b1;
          end else begin
            for (int k = 0; k < TAIL_LEN - 1; k++) begin
              name_tail_next[k] = name_tail_next[k+1];
            end
            name_tail_next[TAIL_LEN-1] = head_word.data_byte;
            if (name_tail_fill_next < 4'(TAIL_LEN)) begin
              name_tail_fill_next = name_tail_fill_next + 1'b1;
            end
          end
        end
        if (header_count_next >= 9'(SIZE_FIRST) && header_count_next <= 9'(SIZE_LAST)) begin
          if (size_phase_next == SZ_SKIP) begin
            if (head_word.cls.is_ws) begin
              size_phase_next = SZ_SKIP;
            end else if (head_word.cls.is_plus) begin
              size_phase_next = SZ_DIGITS;
            end else if (head_word.cls.is_minus) begin
              size_accum_next = '0;
              size_phase_next = SZ_DONE;
            end else begin
              digit_ok = 1'b1;
            end
          end else if (size_phase_next == SZ_DIGITS) begin
            digit_ok = 1'b1;
          end
          if (digit_ok) begin
            if (head_word.cls.is_octal) begin
              size_phase_next = SZ_DIGITS;
              shifted = {size_accum_next, head_word.data_byte[2:0]};
              size_accum_next = (shifted[33:31] != 3'b000) ? SIZE_MAX : shifted[30:0];
            end else begin
              size_phase_next = SZ_DONE;
            end
          end
        end
        if (header_count_next == 9'(BLOCK_LAST)) begin
          do_clear = 1'b1;
          if (!any_nonzero_next) begin
            aend       = 1'b1;
            phase_next = PH_ENDED;
          end else begin
            hc = 1'b1;
            tail_match = (name_tail_fill_next >= 4'(TAIL_LEN));
            for (int k = 0; k < TAIL_LEN; k++) begin
              if (name_tail_next[k] != CFG_NAME[k]) begin
                tail_match = 1'b0;
              end
            end
            current_size_next    = size_accum_next;
            config_flag_next     = tail_match;
            remaining_bytes_next = size_accum_next;
            phase_next = (size_accum_next == '0) ? PH_HEADER : PH_CONTENT;
          end
        end else begin
          header_count_next = header_count_next + 1'b1;
        end
      end
      PH_CONTENT: begin
        kind = config_flag ? KIND_CONFIG : KIND_FILE;
        remaining_bytes_next = dec;
        if (dec == '0) begin
          // pad up to the next block boundary
          pad      = 9'(9'd0 - current_size[8:0]);
          do_clear = 1'b1;
          if (pad != '0) begin
            remaining_bytes_next = {22'd0, pad};
            phase_next           = PH_PADDING;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_PADDING: begin
        kind = KIND_PADDING;
        remaining_bytes_next = dec;
        if (dec == '0) begin
          do_clear   = 1'b1;
          phase_next = PH_HEADER;
        end
      end
      PH_ENDED: begin
        kind = KIND_IGNORED;
      end
      default: begin
        kind = KIND_IGNORED;
      end
    endcase

    if (do_clear) begin
      header_count_next   = '0;
      any_nonzero_next    = 1'b0;
      name_ended_next     = 1'b0;
      name_tail_fill_next = '0;
      size_accum_next     = '0;
      size_phase_next     = SZ_SKIP;
      for (int k = 0; k < TAIL_LEN; k++) begin
        name_tail_next[k] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ENDED;
      header_count    <= '0;
      any_nonzero     <= 1'b0;
      name_ended      <= 1'b0;
      name_tail_fill  <= '0;
      size_accum      <= '0;
      size_phase      <= SZ_SKIP;
      remaining_bytes <= '0;
      current_size    <= '0;
      config_flag     <= 1'b0;
      for (int k = 0; k < TAIL_LEN; k++) begin
        name_tail[k] <= 8'h00;
      end
      labeled.valid <= 1'b0;
    end else begin
      if (pop) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        any_nonzero     <= any_nonzero_next;
        name_ended      <= name_ended_next;
        name_tail_fill  <= name_tail_fill_next;
        size_accum      <= size_accum_next;
        size_phase      <= size_phase_next;
        remaining_bytes <= remaining_bytes_next;
        current_size    <= current_size_next;
        config_flag     <= config_flag_next;
        for (int k = 0; k < TAIL_LEN; k++) begin
          name_tail[k] <= name_tail_next[k];
        end
        labeled.valid <= 1'b1;
      end else if (labeled.ready) begin
        labeled.valid <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      labeled.byte_kind       <= kind;
      labeled.data_out        <= head_word.data_byte;
      labeled.header_complete <= hc;
      labeled.entry_size      <= current_size_next;
      labeled.entry_is_config <= config_flag_next;
      labeled.archive_end     <= aend;
      labeled.chunk_last_out  <= head_word.chunk_last;
    end
  end

  a_end_or_complete: assert property (@(posedge clk) disable iff (rst)
    labeled.valid |-> !(labeled.header_complete && labeled.archive_end))
    else $error("header both complete and end of archive");

  a_flags_on_header: assert property (@(posedge clk) disable iff (rst)
    labeled.valid && (labeled.header_complete || labeled.archive_end)
      |-> labeled.byte_kind == KIND_HEADER)
    else $error("block flag on a non-header byte");

  a_content_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CONTENT || phase == PH_PADDING) |-> remaining_bytes != '0)
    else $error("content or padding phase with nothing left");

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    pop && labeled.archive_end == 1'b0 && aend |=> phase == PH_ENDED)
    else $error("all-zero header did not end the archive");

endmodule

// ----- hdl/tar_stream_deframer.sv -----
// Top level: tar stream deframer, labels each archive byte and reports entries.
//
//   channel    modport  word carries
//   ---------  -------  ------------------------------------------------------
//   archive    sink     data_byte, start_of_archive, chunk_last
//   labeled    source   byte_kind, data_out, header_complete, entry_size,
//                       entry_is_config, archive_end, chunk_last_out
//
// Throughput: one byte per cycle unless labeled stalls; each word passes through
//   a queue slot and then the output register.
// Rate is set by the back part: one queued word per cycle unless labeled stalls.
// Reset: synchronous on rst; the parser comes up in the ended phase and
//   ignores bytes until a word with start_of_archive arrives.
// Stalls: the queue takes words while the output register waits; archive.ready
//   drops only when all QUEUE_DEPTH slots are full.
module tar_stream_deframer import tsd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  tsd_in_if.sink    archive,
  tsd_out_if.source labeled
);

  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;
  queue_word_t push_word;
  queue_word_t head_word;

  // Classify each byte as it is taken (whitespace, sign, octal digit, zero).
  tsd_front u_front (
    .archive (archive),
    .full    (full),
    .push    (push),
    .word    (push_word)
  );

  // Decouple intake from the parser so either side can stall on its own.
  tsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // Walk header, content and padding; advance one word per cycle when the
  // output register is free or being drained.
  tsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .labeled    (labeled)
  );

endmodule
